// File: design/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared widths, limits and opcodes for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int MAX_DUMP         = 16;   // most beats one dump emits
  localparam int OP_W             = 4;
  localparam int VAL_W            = 32;
  localparam int POS_W            = 5;
  localparam int LEN_W            = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND       = 4'd0,
    OP_PREPEND      = 4'd1,
    OP_INSERT       = 4'd2,
    OP_UNIQUE_APPND = 4'd3,
    OP_POP_FRONT    = 4'd4,
    OP_POP_BACK     = 4'd5,
    OP_REMOVE_AT    = 4'd6,
    OP_REMOVE_FIRST = 4'd7,
    OP_REMOVE_ALL   = 4'd8,
    OP_DUMP         = 4'd9
  } op_t;

endpackage

// File: design/ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Ordered list of signed 32-bit values kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: opcode,
//   operand value and position. Output channel (out_valid/out_ready)
//   returns result beats. Every command answers one beat with status and
//   the new length, except dump, which answers one beat per entry (at most
//   16, in list order, last one flagged) and none on an empty list.
//   Sequencing: one command at a time. Append goes through the place and
//   result states; pop back and commands rejected at accept go straight to
//   the result state. Insert/prepend walk the tail once (grow, then place),
//   unique append reads up to every entry once (scan), and every other
//   remove sweeps the whole list once (pack).
//   The cost is set by the single registered RAM read port: one entry per
//   cycle. Dump streams one entry per cycle while the receiver takes
//   beats.
//   Reset clears length and state, not RAM; RAM is never read above length.
//   A result waits in the output register while the receiver stalls; the
//   engine takes the next command meanwhile and holds its own result until
//   the register frees up.
// ----------------------------------------------------------------------------
module ordered_list_engine_top #(
  parameter int CAPACITY = ole_pkg::DEFAULT_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ole_pkg::OP_W-1:0]         in_opcode,
  input  logic signed [ole_pkg::VAL_W-1:0] in_operand_value,
  input  logic [ole_pkg::POS_W-1:0]        in_position,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_status,
  output logic signed [ole_pkg::VAL_W-1:0] out_item_value,
  output logic                             out_last_of_run,
  output logic [ole_pkg::LEN_W-1:0]        out_list_length
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;   // RAM address
  localparam int CW  = $clog2(CAPACITY + 1);                    // length
  localparam int PW  = (CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W;
  localparam int VW  = ole_pkg::VAL_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_GROW  = 7'b0000010,   // shift tail up by one, top down
    ST_PLACE = 7'b0000100,   // write the new value into the opened slot
    ST_SCAN  = 7'b0001000,   // duplicate search for unique append
    ST_PACK  = 7'b0010000,   // compact the list, dropping selected entries
    ST_DUMP  = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_t;

  // --------------------------------------------------------------------------
  // Entry RAM: one write port, one registered read port. No access pattern
  // below reads an entry in the cycle it is written (grow reads below its
  // write address, pack reads above it), so no forwarding is needed.
  // --------------------------------------------------------------------------
  logic [VW-1:0] mem [CAPACITY];
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [VW-1:0] wd;
  logic [VW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  // --------------------------------------------------------------------------
  // Control and working registers
  // --------------------------------------------------------------------------
  state_t        st_r, st_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] at_r, at_nxt;          // insert slot or drop index
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;  // index of the read in flight
  logic [CW-1:0] keep_r, keep_nxt;      // write pointer while packing
  logic [CW-1:0] dlast_r, dlast_nxt;    // index of last dumped entry
  logic [VW-1:0] val_r, val_nxt;
  logic          pend_r, pend_nxt;      // read data valid this cycle
  logic          found_r, found_nxt;
  logic          by_val_r, by_val_nxt;  // pack drops by value match
  logic          all_r, all_nxt;        // pack drops every match
  logic          stat_r, stat_nxt;

  logic              ov_r, ov_nxt;
  logic              os_r, os_nxt;
  logic [VW-1:0]     oval_r, oval_nxt;
  logic              olast_r, olast_nxt;
  logic [CW-1:0]     olen_r, olen_nxt;

  logic          can_load;
  logic          full;
  logic [CW-1:0] cnt_m1;
  logic          rd_is_last;
  logic          match;
  logic          drop;
  ole_pkg::op_t  op;

  assign can_load   = !ov_r || out_ready;
  assign full       = (count_r == CW'(CAPACITY));
  assign cnt_m1     = count_r - CW'(1);
  assign rd_is_last = (CW'(rd_idx_r) == cnt_m1);
  assign match      = (rd_data_r == val_r);
  assign drop       = by_val_r ? (match && (all_r || !found_r)) : (rd_idx_r == at_r);
  assign op         = ole_pkg::op_t'(in_opcode);

  assign in_ready   = (st_r == ST_IDLE);

  always_comb begin
    st_nxt     = st_r;
    count_nxt  = count_r;
    at_nxt     = at_r;
    rd_idx_nxt = rd_idx_r;
    keep_nxt   = keep_r;
    dlast_nxt  = dlast_r;
    val_nxt    = val_r;
    pend_nxt   = pend_r;
    found_nxt  = found_r;
    by_val_nxt = by_val_r;
    all_nxt    = all_r;
    stat_nxt   = stat_r;
    ov_nxt     = ov_r && !out_ready;
    os_nxt     = os_r;
    oval_nxt   = oval_r;
    olast_nxt  = olast_r;
    olen_nxt   = olen_r;
    we         = 1'b0;
    wa         = '0;
    wd         = val_r;
    re         = 1'b0;
    ra         = rd_idx_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt    = in_operand_value;
          stat_nxt   = 1'b0;
          pend_nxt   = 1'b0;
          found_nxt  = 1'b0;
          keep_nxt   = '0;
          rd_idx_nxt = '0;
          by_val_nxt = 1'b0;
          all_nxt    = 1'b0;
          st_nxt     = ST_RESP;
          unique case (op) inside
            ole_pkg::OP_APPEND: begin
              if (full) begin
                stat_nxt = 1'b1;
              end else begin
                at_nxt = AW'(count_r);
                st_nxt = ST_PLACE;
              end
            end
            ole_pkg::OP_PREPEND, ole_pkg::OP_INSERT: begin
              if (full || ((op == ole_pkg::OP_INSERT) && (PW'(in_position) > PW'(count_r))))
              begin
                stat_nxt = 1'b1;
              end else begin
                at_nxt = (op == ole_pkg::OP_INSERT) ? AW'(in_position) : '0;
                if (((op == ole_pkg::OP_INSERT) && (PW'(in_position) == PW'(count_r))) ||
                    (count_r == '0)) begin
                  st_nxt = ST_PLACE;
                end else begin
                  rd_idx_nxt = AW'(cnt_m1);
                  st_nxt     = ST_GROW;
                end
              end
            end
            ole_pkg::OP_UNIQUE_APPND: begin
              at_nxt = AW'(count_r);
              if (full) begin
                stat_nxt = 1'b1;
              end else if (count_r == '0) begin
                st_nxt = ST_PLACE;
              end else begin
                st_nxt = ST_SCAN;
              end
            end
            ole_pkg::OP_POP_BACK: begin
              if (count_r != '0) begin
                count_nxt = cnt_m1;
              end
            end
            ole_pkg::OP_POP_FRONT, ole_pkg::OP_REMOVE_AT,
            ole_pkg::OP_REMOVE_FIRST, ole_pkg::OP_REMOVE_ALL: begin
              by_val_nxt = (op == ole_pkg::OP_REMOVE_FIRST) || (op == ole_pkg::OP_REMOVE_ALL);
              all_nxt    = (op == ole_pkg::OP_REMOVE_ALL);
              at_nxt     = (op == ole_pkg::OP_REMOVE_AT) ? (AW'(in_position) - AW'(1)) : '0;
              if ((op == ole_pkg::OP_REMOVE_AT) &&
                  ((in_position == '0) || (PW'(in_position) > PW'(count_r)))) begin
                stat_nxt = 1'b1;
              end else if (count_r != '0) begin
                st_nxt = ST_PACK;
              end
            end
            ole_pkg::OP_DUMP: begin
              if (count_r == '0) begin
                st_nxt = ST_IDLE;   // empty list: no beats at all
              end else begin
                dlast_nxt = (int'(count_r) > ole_pkg::MAX_DUMP) ?
                            CW'(ole_pkg::MAX_DUMP - 1) : cnt_m1;
                st_nxt    = ST_DUMP;
              end
            end
            default: begin
              stat_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_GROW: begin
        if (!pend_r) begin
          re       = 1'b1;
          pend_nxt = 1'b1;
        end else begin
          // move entry rd_idx up one slot, then fetch the one below
          we = 1'b1;
          wa = rd_idx_r + AW'(1);
          wd = rd_data_r;
          if (rd_idx_r == at_r) begin
            pend_nxt = 1'b0;
            st_nxt   = ST_PLACE;
          end else begin
            re         = 1'b1;
            ra         = rd_idx_r - AW'(1);
            rd_idx_nxt = rd_idx_r - AW'(1);
          end
        end
      end

      ST_PLACE: begin
        we        = 1'b1;
        wa        = at_r;
        wd        = val_r;
        count_nxt = count_r + CW'(1);
        st_nxt    = ST_RESP;
      end

      ST_SCAN: begin
        if (!pend_r) begin
          re       = 1'b1;
          pend_nxt = 1'b1;
        end else if (match) begin
          stat_nxt = 1'b1;
          pend_nxt = 1'b0;
          st_nxt   = ST_RESP;
        end else if (rd_is_last) begin
          pend_nxt = 1'b0;
          st_nxt   = ST_PLACE;
        end else begin
          re         = 1'b1;
          ra         = rd_idx_r + AW'(1);
          rd_idx_nxt = rd_idx_r + AW'(1);
        end
      end

      ST_PACK: begin
        if (!pend_r) begin
          re       = 1'b1;
          pend_nxt = 1'b1;
        end else begin
          // keep entries slide down to the write pointer, dropped ones vanish
          if (drop) begin
            found_nxt = 1'b1;
          end else begin
            we       = 1'b1;
            wa       = AW'(keep_r);
            wd       = rd_data_r;
            keep_nxt = keep_r + CW'(1);
          end
          if (rd_is_last) begin
            count_nxt = drop ? keep_r : (keep_r + CW'(1));
            pend_nxt  = 1'b0;
            st_nxt    = ST_RESP;
          end else begin
            re         = 1'b1;
            ra         = rd_idx_r + AW'(1);
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
        end
      end

      ST_DUMP: begin
        if (!pend_r) begin
          re       = 1'b1;
          pend_nxt = 1'b1;
        end else if (can_load) begin
          ov_nxt    = 1'b1;
          os_nxt    = 1'b0;
          oval_nxt  = rd_data_r;
          olast_nxt = (CW'(rd_idx_r) == dlast_r);
          olen_nxt  = count_r;
          if (CW'(rd_idx_r) == dlast_r) begin
            pend_nxt = 1'b0;
            st_nxt   = ST_IDLE;
          end else begin
            re         = 1'b1;
            ra         = rd_idx_r + AW'(1);
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
        end
      end

      ST_RESP: begin
        if (can_load) begin
          ov_nxt    = 1'b1;
          os_nxt    = stat_r;
          oval_nxt  = '0;
          olast_nxt = 1'b1;
          olen_nxt  = count_r;
          st_nxt    = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload and working registers: no reset needed
  always_ff @(posedge clk) begin
    at_r     <= at_nxt;
    rd_idx_r <= rd_idx_nxt;
    keep_r   <= keep_nxt;
    dlast_r  <= dlast_nxt;
    val_r    <= val_nxt;
    found_r  <= found_nxt;
    by_val_r <= by_val_nxt;
    all_r    <= all_nxt;
    stat_r   <= stat_nxt;
    os_r     <= os_nxt;
    oval_r   <= oval_nxt;
    olast_r  <= olast_nxt;
    olen_r   <= olen_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_item_value  = oval_r;
  assign out_last_of_run = olast_r;
  assign out_list_length = ole_pkg::LEN_W'(olen_r);

endmodule

// File: tb/ordered_list_engine_top_tb.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_top_tb
// Self-checking regression for the ordered list engine.
// ----------------------------------------------------------------------------
// A queue of commands feeds a clocked driver on the input channel. A clocked
// monitor takes every accepted command into a shadow list, queues the result
// beats the shadow list predicts, and checks each returned beat against the
// oldest one, field by field. A directed opening covers the corner cases.
// Random phases follow with no idling, a sparse sender, a stalling receiver
// and both at once. A final phase holds the receiver off until the engine
// backs up onto its input.
// ----------------------------------------------------------------------------
module ordered_list_engine_top_tb;

  localparam int CAPACITY    = ole_pkg::DEFAULT_CAPACITY;
  localparam int MAX_DUMP    = ole_pkg::MAX_DUMP;
  localparam int OP_W        = ole_pkg::OP_W;
  localparam int VAL_W       = ole_pkg::VAL_W;
  localparam int POS_W       = ole_pkg::POS_W;
  localparam int LEN_W       = ole_pkg::LEN_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 64;   // wait after the final drain before the last check
  localparam int BATCH       = 6;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
  } list_cmd_t;

  typedef struct {
    logic                    status;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic [LEN_W-1:0]        length;
  } list_beat_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [OP_W-1:0]         in_opcode;
  logic signed [VAL_W-1:0] in_operand_value;
  logic [POS_W-1:0]        in_position;
  logic                    out_valid;
  logic                    out_ready;
  logic                    out_status;
  logic signed [VAL_W-1:0] out_item_value;
  logic                    out_last_of_run;
  logic [LEN_W-1:0]        out_list_length;

  // Shadow copy of the list, updated when a command beat is accepted.
  logic signed [VAL_W-1:0] list_image [CAPACITY];
  int                      list_len;

  list_cmd_t  cmd_backlog[$];
  list_beat_t expected_beats[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  bit  squeeze_go;
  bit  in_took;
  int  cycle_count;
  int  mismatch_count;

  ordered_list_engine_top #(.CAPACITY(CAPACITY)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_operand_value (in_operand_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_item_value   (out_item_value),
    .out_last_of_run  (out_last_of_run),
    .out_list_length  (out_list_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0d] mismatch: %s", cycle_count, what);
    end
    mismatch_count++;
  endtask

  // Shift the tail up by one and drop the value into the gap.
  task automatic open_slot(input int at, input logic signed [VAL_W-1:0] val);
    for (int i = list_len; i > at; i--) begin
      list_image[i] = list_image[i-1];
    end
    list_image[at] = val;
    list_len++;
  endtask

  // Close the gap at one entry by shifting the tail down.
  task automatic close_slot(input int at);
    for (int i = at; i + 1 < list_len; i++) begin
      list_image[i] = list_image[i+1];
    end
    list_len--;
  endtask

  // Apply one command to the shadow list and queue the beats it answers with.
  task automatic apply_list_op(input logic [OP_W-1:0] op,
                               input logic signed [VAL_W-1:0] val,
                               input logic [POS_W-1:0] pos);
    bit         fail;
    bit         full;
    int         hit;
    int         kept;
    int         n;
    list_beat_t beat;
    fail = 1'b0;
    full = (list_len >= CAPACITY);
    hit  = -1;
    for (int i = 0; i < list_len; i++) begin
      if (hit < 0 && list_image[i] == val) hit = i;
    end
    case (op)
      ole_pkg::OP_APPEND: begin
        if (full) fail = 1'b1; else open_slot(list_len, val);
      end
      ole_pkg::OP_PREPEND: begin
        if (full) fail = 1'b1; else open_slot(0, val);
      end
      ole_pkg::OP_INSERT: begin
        if (full || pos > list_len) fail = 1'b1; else open_slot(pos, val);
      end
      ole_pkg::OP_UNIQUE_APPND: begin
        if (full || hit >= 0) fail = 1'b1; else open_slot(list_len, val);
      end
      ole_pkg::OP_POP_FRONT: begin
        if (list_len > 0) close_slot(0);
      end
      ole_pkg::OP_POP_BACK: begin
        if (list_len > 0) list_len--;
      end
      ole_pkg::OP_REMOVE_AT: begin
        if (pos == 0 || pos > list_len) fail = 1'b1; else close_slot(pos - 1);
      end
      ole_pkg::OP_REMOVE_FIRST: begin
        if (hit >= 0) close_slot(hit);
      end
      ole_pkg::OP_REMOVE_ALL: begin
        kept = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_image[i] != val) begin
            list_image[kept] = list_image[i];
            kept++;
          end
        end
        list_len = kept;
      end
      ole_pkg::OP_DUMP: begin
        n = (list_len < MAX_DUMP) ? list_len : MAX_DUMP;
        for (int i = 0; i < n; i++) begin
          beat.status = 1'b0;
          beat.value  = list_image[i];
          beat.last   = (i + 1 == n);
          beat.length = list_len[LEN_W-1:0];
          expected_beats.push_back(beat);
        end
        return;
      end
      default: fail = 1'b1;
    endcase
    beat.status = fail;
    beat.value  = '0;
    beat.last   = 1'b1;
    beat.length = list_len[LEN_W-1:0];
    expected_beats.push_back(beat);
  endtask

  task automatic queue_cmd(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    list_cmd_t c;
    c.op  = op;
    c.val = val;
    c.pos = pos;
    cmd_backlog.push_back(c);
  endtask

  // Mostly a small pool so that duplicates and matches are common.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(5);
    if (r < 65) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -32'sd1;
        default: return 32'sh5555_aaaa;
      endcase
    end
    return $urandom;
  endfunction

  // Draw one random command, steered by the current length of the list.
  task automatic queue_random_cmd();
    int               r;
    int               grow_pct;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    r = $urandom_range(99);
    grow_pct = (list_len < 6) ? 70 : ((list_len > 13) ? 40 : 55);
    if (r < 3) op = OP_W'($urandom_range(15, int'(ole_pkg::OP_DUMP) + 1));
    else if (r < 11) op = ole_pkg::OP_DUMP;
    else if (r < grow_pct)
      op = OP_W'($urandom_range(int'(ole_pkg::OP_UNIQUE_APPND), int'(ole_pkg::OP_APPEND)));
    else
      op = OP_W'($urandom_range(int'(ole_pkg::OP_REMOVE_ALL), int'(ole_pkg::OP_POP_FRONT)));
    if ($urandom_range(4) == 0) pos = POS_W'($urandom_range(16));
    else pos = POS_W'($urandom_range((list_len < 16) ? list_len + 1 : 16));
    queue_cmd(op, pick_value(), pos);
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_valid || expected_beats.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int done = 0; done < count; done += BATCH) begin
      wait_drained();
      for (int k = 0; k < BATCH; k++) queue_random_cmd();
    end
    wait_drained();
  endtask

  // Driver: present the next command at the falling edge; hold it until taken.
  always @(negedge clk) begin
    list_cmd_t c;
    if (rst_n && (!in_valid || in_took)) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = cmd_backlog.pop_front();
        in_valid         <= 1'b1;
        in_opcode        <= c.op;
        in_operand_value <= c.val;
        in_position      <= c.pos;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= hold_off ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: take accepted commands into the shadow list, check result beats.
  always @(posedge clk) begin
    list_beat_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ordered_list_engine_top regression: fail");
      $finish;
    end else begin
      in_took = rst_n && in_valid && in_ready;
      if (in_took) apply_list_op(in_opcode, in_operand_value, in_position);
      if (rst_n && out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          note_mismatch($sformatf("unexpected beat value %0d", out_item_value));
        end else begin
          want = expected_beats.pop_front();
          if (out_status !== want.status)
            note_mismatch($sformatf("status %b want %b", out_status, want.status));
          if (out_item_value !== want.value)
            note_mismatch($sformatf("item_value %0d want %0d", out_item_value, want.value));
          if (out_last_of_run !== want.last)
            note_mismatch($sformatf("last_of_run %b want %b", out_last_of_run, want.last));
          if (out_list_length !== want.length)
            note_mismatch($sformatf("list_length %0d want %0d", out_list_length,
                                    want.length));
        end
      end
    end
  end

  // Receiver hold-off: block the result channel long enough to back up the input.
  initial begin
    int held;
    hold_off = 1'b0;
    wait (squeeze_go);
    @(posedge clk);
    hold_off = 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = '0;
    in_operand_value = '0;
    in_position      = '0;
    out_ready        = 1'b0;
    in_took          = 1'b0;
    squeeze_go       = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    list_len         = 0;
    cycle_count      = 0;
    mismatch_count   = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Empty list: removes succeed untouched, a dump answers nothing,
    // bad positions fail.
    queue_cmd(ole_pkg::OP_POP_FRONT, 0, 0);
    queue_cmd(ole_pkg::OP_POP_BACK, 0, 0);
    queue_cmd(ole_pkg::OP_REMOVE_FIRST, 32'sd3, 0);
    queue_cmd(ole_pkg::OP_REMOVE_ALL, 32'sd3, 0);
    queue_cmd(ole_pkg::OP_DUMP, 0, 0);
    queue_cmd(ole_pkg::OP_REMOVE_AT, 0, 1);
    queue_cmd(ole_pkg::OP_INSERT, 32'sd9, 1);
    // Build up with extreme values; a duplicate unique append fails.
    queue_cmd(ole_pkg::OP_INSERT, 32'sh8000_0000, 0);
    queue_cmd(ole_pkg::OP_APPEND, 32'sh7fff_ffff, 0);
    queue_cmd(ole_pkg::OP_PREPEND, -32'sd1, 0);
    queue_cmd(ole_pkg::OP_UNIQUE_APPND, -32'sd1, 0);
    queue_cmd(ole_pkg::OP_UNIQUE_APPND, 32'sd0, 0);
    queue_cmd(ole_pkg::OP_INSERT, 32'sh5555_5555, 2);
    // Fill the store; repeated sevens feed the remove-all below.
    for (int k = 0; k < 11; k++) begin
      queue_cmd(ole_pkg::OP_APPEND, (k == 10) ? 32'sh0f0f_0f0f : (k == 9) ? 32'sh1234_5678 :
                                    (k % 2 == 0) ? 32'sd7 : $urandom, 0);
    end
    // Full store: every add fails.
    queue_cmd(ole_pkg::OP_APPEND, 32'sd1, 0);
    queue_cmd(ole_pkg::OP_PREPEND, 32'sd1, 0);
    queue_cmd(ole_pkg::OP_INSERT, 32'sd1, 16);
    queue_cmd(ole_pkg::OP_UNIQUE_APPND, 32'sd1, 0);
    queue_cmd(ole_pkg::OP_DUMP, 0, 0);
    // Remove the very last entry, then match on the new last entry.
    queue_cmd(ole_pkg::OP_REMOVE_AT, 0, 16);
    queue_cmd(ole_pkg::OP_REMOVE_FIRST, 32'sh1234_5678, 0);
    queue_cmd(ole_pkg::OP_REMOVE_AT, 0, 0);
    queue_cmd(ole_pkg::OP_REMOVE_AT, 0, 16);
    queue_cmd(ole_pkg::OP_REMOVE_ALL, 32'sd7, 0);
    queue_cmd(ole_pkg::OP_DUMP, 0, 0);
    queue_cmd(4'hf, 0, 0);
    queue_cmd(4'ha, 0, 0);
    wait_drained();

    run_random(96, 0, 0);
    run_random(96, 84, 0);
    run_random(96, 0, 84);
    run_random(96, 32, 32);

    // Back-pressure: keep offering commands while the receiver is held off.
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    squeeze_go     = 1'b1;
    for (int k = 0; k < 30; k++) queue_random_cmd();
    wait_drained();

    repeat (DRAIN_WAIT) @(negedge clk);
    if (expected_beats.size() != 0) begin
      note_mismatch($sformatf("%0d result beats never arrived", expected_beats.size()));
    end
    if (mismatch_count == 0) begin
      $display("ordered_list_engine_top regression: pass");
    end else begin
      $display("ordered_list_engine_top regression: fail");
    end
    $finish;
  end

endmodule
